// ===== design/mspa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspa_pkg
// Shared types and codes for the matching slot pool allocator: request and
// response words, status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mspa_pkg;

    // Default pool depth
    localparam int MAX_SLOTS_DEF = 16;

    // Field widths fixed by the word format
    localparam int DIM_W  = 16;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 2;
    localparam int KEY_W  = 2 * DIM_W + 2;

    // Request kinds
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_REL = 2'd2;

    // Input word
    typedef struct packed {
        logic             req_type;
        logic [DIM_W-1:0] buf_width;
        logic [DIM_W-1:0] buf_height;
        logic             hdr_format;
        logic             depth_stencil;
        logic [IDX_W-1:0] release_slot;
    } t_req;

    // Output word
    typedef struct packed {
        logic [IDX_W-1:0]  slot_index;
        logic              created;
        logic [STAT_W-1:0] status;
    } t_rsp;

    // Controller -> datapath commands
    typedef struct packed {
        logic load_req;    // capture request, restart scan
        logic scan_step;   // issue next key read
        logic grant;       // grant the matching slot
        logic append;      // create a new busy slot
        logic fail_full;   // answer pool full
        logic release_op;  // free the named slot
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic in_is_release;
        logic hit;
        logic scan_done;
        logic pool_full;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/mspa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/mspa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspa_ctrl
// Sequencer for the allocator: takes a request word, runs the key scan,
// then issues exactly one finishing command once the output is free.
// ----------------------------------------------------------------------------
module mspa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mspa_pkg::t_sts i_sts,
    output mspa_pkg::t_cmd      o_cmd
);
    import mspa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_REL  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = i_sts.in_is_release ? S_REL : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    // hold the compare stage until the output can take the word
                    if (i_sts.out_free) begin
                        o_cmd.grant = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (i_sts.scan_done) begin
                    if (i_sts.out_free) begin
                        if (i_sts.pool_full) begin
                            o_cmd.fail_full = 1'b1;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_REL: begin
                if (i_sts.out_free) begin
                    o_cmd.release_op = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // At most one finishing command per cycle
    a_one_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.grant, o_cmd.append, o_cmd.fail_full, o_cmd.release_op}))
        else $error("more than one finishing command");

    // A finishing command never overwrites a pending output word
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.grant || o_cmd.append || o_cmd.fail_full || o_cmd.release_op)
        |-> i_sts.out_free)
        else $error("output overwritten");

    // A slot is appended only after a full miss and with room left
    a_append_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.append |-> (i_sts.scan_done && !i_sts.pool_full && !i_sts.hit))
        else $error("append without a clean miss");

endmodule
`default_nettype wire

// ===== design/mspa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspa_dp
// Allocator datapath: request capture, slot count, busy marks, key RAM with
// a compare pipeline that checks one slot per cycle until a hit, and the output register.
// ----------------------------------------------------------------------------
module mspa_dp #(
    parameter int MAX_SLOTS = mspa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mspa_pkg::t_req i_in_data,
    input  wire mspa_pkg::t_cmd i_cmd,
    output mspa_pkg::t_sts      o_sts,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output mspa_pkg::t_rsp      o_out_data
);
    import mspa_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int RW = (CW > IDX_W) ? CW : IDX_W;

    t_req              r_req;
    logic [CW-1:0]     r_count;
    logic [MAX_SLOTS-1:0] r_busy;
    logic [CW-1:0]     r_rd_idx;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    t_rsp              r_out;
    t_rsp              n_out;
    logic              r_out_vld;
    logic              w_out_load;

    logic [KEY_W-1:0]  w_key;
    logic [KEY_W-1:0]  w_rd_key;
    logic              w_rd_more;
    logic              w_hit;
    logic              w_rel_ok;
    logic              w_full;
    logic              w_rd_en;
    logic [IW-1:0]     w_rel_idx;

    // Key of the held request
    assign w_key = {r_req.buf_width, r_req.buf_height, r_req.hdr_format,
                    r_req.depth_stencil};

    // Scan and decision terms
    assign w_rd_more = (r_rd_idx < r_count);
    assign w_rd_en   = i_cmd.scan_step && w_rd_more;
    assign w_hit     = r_cmp_vld && !r_busy[r_cmp_idx] && (w_rd_key == w_key);
    assign w_full    = (r_count == CW'(MAX_SLOTS));
    assign w_rel_ok  = (RW'(r_req.release_slot) < RW'(r_count));
    assign w_rel_idx = IW'(r_req.release_slot);

    assign o_sts.in_is_release = (i_in_data.req_type == REQ_RELEASE);
    assign o_sts.hit           = w_hit;
    assign o_sts.scan_done     = !r_cmp_vld && !w_rd_more;
    assign o_sts.pool_full     = w_full;
    assign o_sts.out_free      = !r_out_vld || i_out_ready;

    // Key store: written on append, read by the scan
    mspa_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_SLOTS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.append),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (w_key),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx[IW-1:0]),
        .o_rd_data (w_rd_key)
    );

    // Result word for the finishing command
    always_comb begin
        n_out      = r_out;
        w_out_load = 1'b1;
        if (i_cmd.grant) begin
            n_out.slot_index = IDX_W'(r_cmp_idx);
            n_out.created    = 1'b0;
            n_out.status     = ST_OK;
        end else if (i_cmd.append) begin
            n_out.slot_index = IDX_W'(r_count[IW-1:0]);
            n_out.created    = 1'b1;
            n_out.status     = ST_OK;
        end else if (i_cmd.fail_full) begin
            n_out.slot_index = '0;
            n_out.created    = 1'b0;
            n_out.status     = ST_FULL;
        end else if (i_cmd.release_op) begin
            n_out.slot_index = '0;
            n_out.created    = 1'b0;
            n_out.status     = w_rel_ok ? ST_OK : ST_BAD_REL;
        end else begin
            w_out_load = 1'b0;
        end
    end

    // Control state: count, busy marks, compare valid, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_busy    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load_req) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= w_rd_more;
            end

            if (i_cmd.grant) begin
                r_busy[r_cmp_idx] <= 1'b1;
            end
            if (i_cmd.append) begin
                r_busy[r_count[IW-1:0]] <= 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.release_op && w_rel_ok) begin
                r_busy[w_rel_idx] <= 1'b0;
            end

            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: request, scan pointers, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req    <= i_in_data;
            r_rd_idx <= '0;
        end else if (w_rd_en) begin
            r_rd_idx  <= r_rd_idx + 1'b1;
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Slot count never passes the pool size
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SLOTS))
        else $error("slot count overflow");

    // Compare stage only looks at created slots
    a_cmp_created: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (CW'(r_cmp_idx) < r_count))
        else $error("compare of uncreated slot");

    // A granted slot is busy afterwards
    a_grant_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.grant |=> r_busy[$past(r_cmp_idx)])
        else $error("granted slot not marked busy");

endmodule
`default_nettype wire

// ===== design/matching_slot_pool_allocator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matching_slot_pool_allocator_top
// Pool of buffer slots keyed by width, height, HDR and depth-stencil flags.
//
// Request channel (i_in_valid / o_in_ready / i_in_data): an acquire word
// grants the lowest created free slot with an equal key, or appends a new
// busy slot (created = 1), or answers pool full. A release word frees the
// named slot, or answers status 2 if that slot was never created.
// Response channel (o_out_valid / i_out_ready / o_out_data): one word per
// request, in request order, held in an output register.
// Timing: one request at a time. A release answers from the release state
// once the output is free, then the block returns to idle. An acquire reads
// one key per cycle from the key RAM, until a hit or the last created slot,
// and compares it in the cycle after the read, as the read port is registered.
// A miss answers after the last created slot has been compared; a hit on
// slot k answers once slot k is compared and the output is free.
// Reset (synchronous, active low) empties the pool and clears busy marks;
// no clearing pass is needed. When the receiver stalls, the finished word
// waits in the output register; the next request can still be accepted and
// scanned, but its finishing command waits until the word is taken.
// ----------------------------------------------------------------------------
module matching_slot_pool_allocator_top #(
    parameter int MAX_SLOTS = mspa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mspa_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mspa_pkg::t_rsp      o_out_data
);
    import mspa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    mspa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and compare
    mspa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== tb/sv/slot_pool_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_pool_checker
// Watches the request and response channels of the slot pool allocator,
// keeps its own copy of the pool, works out the response word of every
// accepted request and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module slot_pool_checker #(
    parameter int MAX_SLOTS = mspa_pkg::MAX_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  mspa_pkg::t_req i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  mspa_pkg::t_rsp i_out_data,
    output int             o_errors,
    output int             o_waiting,
    output int             o_grants,
    output int             o_appends,
    output int             o_full_answers,
    output int             o_bad_releases
);
    import mspa_pkg::*;

    // Shadow copy of the pool
    logic [$clog2(MAX_SLOTS+1)-1:0] pool_size;
    logic                           slot_taken [MAX_SLOTS];
    logic [DIM_W-1:0]               key_width  [MAX_SLOTS];
    logic [DIM_W-1:0]               key_height [MAX_SLOTS];
    logic                           key_hdr    [MAX_SLOTS];
    logic                           key_depth  [MAX_SLOTS];

    // Response words still owed by the block, oldest first
    t_rsp owed_rsp [$];

    // Apply one request to the shadow pool and return the word it must cause
    function automatic t_rsp grant_for(input t_req r);
        t_rsp rsp;
        bit   found;
        rsp   = '0;
        found = 1'b0;
        rsp.status = ST_OK;
        if (r.req_type == REQ_ACQUIRE) begin
            // first fit: lowest created slot that is free with an equal key
            for (int i = 0; i < MAX_SLOTS; i++) begin
                if (!found && i < pool_size && !slot_taken[i]
                    && key_width[i] == r.buf_width && key_height[i] == r.buf_height
                    && key_hdr[i] == r.hdr_format && key_depth[i] == r.depth_stencil) begin
                    found          = 1'b1;
                    slot_taken[i]  = 1'b1;
                    rsp.slot_index = i[IDX_W-1:0];
                    o_grants++;
                end
            end
            if (!found) begin
                if (pool_size >= MAX_SLOTS) begin
                    rsp.status = ST_FULL;
                    o_full_answers++;
                end else begin
                    slot_taken[pool_size] = 1'b1;
                    key_width[pool_size]  = r.buf_width;
                    key_height[pool_size] = r.buf_height;
                    key_hdr[pool_size]    = r.hdr_format;
                    key_depth[pool_size]  = r.depth_stencil;
                    rsp.slot_index        = pool_size[IDX_W-1:0];
                    rsp.created           = 1'b1;
                    pool_size             = pool_size + 1'b1;
                    o_appends++;
                end
            end
        end else if (r.release_slot < pool_size) begin
            slot_taken[r.release_slot] = 1'b0;
        end else begin
            rsp.status = ST_BAD_REL;
            o_bad_releases++;
        end
        return rsp;
    endfunction

    // Sample both channels at each edge
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            pool_size = '0;
            for (int i = 0; i < MAX_SLOTS; i++) slot_taken[i] = 1'b0;
            owed_rsp.delete();
            o_errors       = 0;
            o_grants       = 0;
            o_appends      = 0;
            o_full_answers = 0;
            o_bad_releases = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_rsp.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected word, expected none, actual %p", $time, i_out_data);
                end else begin
                    want = owed_rsp.pop_front();
                    if (want.slot_index != i_out_data.slot_index) begin
                        o_errors++;
                        $display("%0t: slot_index expected %0d actual %0d",
                                 $time, want.slot_index, i_out_data.slot_index);
                    end
                    if (want.created != i_out_data.created) begin
                        o_errors++;
                        $display("%0t: created expected %0d actual %0d",
                                 $time, want.created, i_out_data.created);
                    end
                    if (want.status != i_out_data.status) begin
                        o_errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_out_data.status);
                    end
                end
            end
            if (i_in_valid && i_in_ready) owed_rsp = {owed_rsp, grant_for(i_in_data)};
        end
        o_waiting <= owed_rsp.size();
    end

endmodule

// ===== tb/sv/matching_slot_pool_allocator_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matching_slot_pool_allocator_top_test
// Drives acquire and release words into the slot pool allocator: a directed
// opening that fills the pool and hits its corner cases, then random traffic
// built mostly from keys already in the pool. Both sides idle at random,
// the receiver stalls once for a long stretch, the sender drains once.
// ----------------------------------------------------------------------------
module matching_slot_pool_allocator_top_test;
    import mspa_pkg::*;

    localparam int POOL_SLOTS = MAX_SLOTS_DEF;
    localparam int RAND_WORDS = 900;
    localparam int HOLD_LEN   = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_KEYS     = 6;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic in_valid  = 1'b0;
    logic in_ready;
    t_req in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rsp out_data;

    // Stimulus-side controls
    logic calm    = 1'b0;
    logic hold_rx = 1'b0;
    int   hold_cycles = 0;
    int   idle_cycles = 0;
    int   directed_n  = 0;

    int errors, waiting, grants, appends, full_answers, bad_releases;

    // Keys that the pool is filled with; random acquires mostly reuse them
    t_req key_pal [N_KEYS];

    always #5 i_clk = ~i_clk;

    matching_slot_pool_allocator_top #(
        .MAX_SLOTS(POOL_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    slot_pool_checker #(
        .MAX_SLOTS(POOL_SLOTS)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_errors      (errors),
        .o_waiting     (waiting),
        .o_grants      (grants),
        .o_appends     (appends),
        .o_full_answers(full_answers),
        .o_bad_releases(bad_releases)
    );

    // Word builders; fields a request kind ignores still get random bits
    function automatic t_req make_acquire(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                          input logic hdr, input logic ds);
        t_req r;
        r.req_type      = REQ_ACQUIRE;
        r.buf_width     = w;
        r.buf_height    = h;
        r.hdr_format    = hdr;
        r.depth_stencil = ds;
        r.release_slot  = IDX_W'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic t_req make_release(input int s);
        t_req r;
        r.req_type      = REQ_RELEASE;
        r.buf_width     = DIM_W'($urandom_range(0, 65535));
        r.buf_height    = DIM_W'($urandom_range(0, 65535));
        r.hdr_format    = 1'($urandom_range(0, 1));
        r.depth_stencil = 1'($urandom_range(0, 1));
        r.release_slot  = IDX_W'(s);
        return r;
    endfunction

    function automatic t_req random_acquire();
        return make_acquire(DIM_W'($urandom_range(0, 65535)), DIM_W'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic t_req palette_acquire(input int k);
        return make_acquire(key_pal[k].buf_width, key_pal[k].buf_height,
                            key_pal[k].hdr_format, key_pal[k].depth_stencil);
    endfunction

    // Offer one word; returns at the edge where it is accepted
    task automatic send_word(input t_req w);
        int gap;
        gap = 0;
        if (!calm) while ($urandom_range(0, 99) < 21) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Receiver: one long hold-off, always ready while calm, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_rx && hold_cycles < HOLD_LEN) begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= 21);
        end
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout at %0t with %0d words outstanding", $time, waiting);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        key_pal[0] = make_acquire(16'h0000, 16'h0000, 1'b0, 1'b0);
        key_pal[1] = make_acquire(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        for (int k = 2; k < N_KEYS; k++) key_pal[k] = random_acquire();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: release into an empty pool, min/max keys,
        // an equal key while its slot is busy, release of a free slot
        send_word(make_release(15));
        send_word(palette_acquire(0));
        send_word(palette_acquire(1));
        send_word(palette_acquire(0));
        send_word(make_release(0));
        send_word(make_release(0));
        send_word(palette_acquire(0));
        send_word(make_release(15));
        // fill the pool while every slot is busy
        for (int k = 3; k < POOL_SLOTS; k++) send_word(palette_acquire(k % N_KEYS));
        // pool full with every slot busy, then with one free slot of another key
        send_word(palette_acquire(2));
        send_word(make_release(3));
        send_word(random_acquire());
        send_word(palette_acquire(3 % N_KEYS));
        directed_n = 12 + POOL_SLOTS - 3;

        // Random traffic
        for (int n = 0; n < RAND_WORDS; n++) begin
            calm <= (n >= 300 && n < 450);
            if (n == 450) begin
                // drain: hold the sender until every word has come back
                in_valid <= 1'b0;
                do @(posedge i_clk); while (waiting != 0);
            end
            if (n == 600) hold_rx <= 1'b1;
            if ($urandom_range(0, 99) < 55) begin
                if ($urandom_range(0, 99) < 75)
                    send_word(palette_acquire($urandom_range(0, N_KEYS - 1)));
                else
                    send_word(random_acquire());
            end else begin
                send_word(make_release($urandom_range(0, 15)));
            end
        end
        in_valid <= 1'b0;

        do @(posedge i_clk); while (waiting != 0);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d directed and %0d random words: %0d grants of free slots, %0d new slots",
                 directed_n, RAND_WORDS, grants, appends);
        $display("Pool-full answers %0d, ignored releases %0d, one long output stall, one drain",
                 full_answers, bad_releases);
        if (errors == 0 && waiting == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
